FILE: rtl/pair_block_sorter_top_macros.svh
// Assertion macros for the pair block sorter.
`ifndef PAIR_BLOCK_SORTER_TOP_MACROS_SVH
`define PAIR_BLOCK_SORTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define PBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pair block sorter check failed");
`define PBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pair block sorter check failed");
`else
`define PBS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PBS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/pbs_pkg.sv
// Shared constants for the pair block sorter.
package pbs_pkg;

	localparam int BLOCK_ENTRIES = 32;
	localparam int KEY_W         = 32;
	localparam int PAIR_W        = 2 * KEY_W;
	localparam int IDX_W         = $clog2(BLOCK_ENTRIES);
	localparam int CNT_W         = $clog2(BLOCK_ENTRIES + 1);

endpackage

FILE: rtl/pbs_in_if.sv
// Input channel: one key pair with its block end mark.
interface pbs_in_if;

	logic                     valid;
	logic                     ready;
	logic [pbs_pkg::KEY_W-1:0] key_high;
	logic [pbs_pkg::KEY_W-1:0] key_low;
	logic                     block_end;

	modport source (output valid, output key_high, output key_low, output block_end,
		input ready);
	modport sink (input valid, input key_high, input key_low, input block_end,
		output ready);

endinterface

FILE: rtl/pbs_out_if.sv
// Output channel: one sorted key pair with run end and drop flags.
interface pbs_out_if;

	logic                     valid;
	logic                     ready;
	logic [pbs_pkg::KEY_W-1:0] out_high;
	logic [pbs_pkg::KEY_W-1:0] out_low;
	logic                     run_end;
	logic                     dropped;

	modport source (output valid, output out_high, output out_low, output run_end,
		output dropped, input ready);
	modport sink (input valid, input out_high, input out_low, input run_end,
		input dropped, output ready);

endinterface

FILE: rtl/pbs_ram.sv
// Generic simple dual port RAM with registered read.
module pbs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/pair_block_sorter_top.sv
// Top level of the pair block sorter: insertion sort over a pair RAM.
//
//  channel  dir  handshake      payload
//  pairs    in   valid/ready    key_high[31:0] key_low[31:0] block_end
//  sorted   out  valid/ready    out_high[31:0] out_low[31:0] run_end dropped
//
// An item is inserted into sorted position as it arrives: each stored pair greater than
// it is moved up one entry, from the top down, until the item finds its place, at the
// latest in the first entry. The single RAM read port and the 64-bit comparator pace
// the insertion: one read and one compare per shifted pair. A dropped item is not stored;
// it sets the drop flag. After a block end, each result is read in EMIT_RD and loaded in
// EMIT_LD, which waits while the sink holds ready low.
// Reset clears every register outside the RAM; the RAM needs no clearing pass.
`include "pair_block_sorter_top_macros.svh"

module pair_block_sorter_top (
	input  logic      clk,
	input  logic      arst_n,
	pbs_in_if.sink    pairs,
	pbs_out_if.source sorted
);

	typedef enum logic [2:0] {
		IDLE,
		INS_RD,
		INS_CMP,
		EMIT_RD,
		EMIT_LD
	} state_t;

	state_t                       state_q;
	logic [pbs_pkg::CNT_W-1:0]    fill_q;
	logic                         ovf_q;
	logic [pbs_pkg::IDX_W-1:0]    pos_q;
	logic [pbs_pkg::IDX_W-1:0]    emit_q;
	logic [pbs_pkg::PAIR_W-1:0]   item_q;
	logic                         last_q;
	logic                         out_valid_q;
	logic [pbs_pkg::KEY_W-1:0]    out_high_q;
	logic [pbs_pkg::KEY_W-1:0]    out_low_q;
	logic                         out_run_end_q;
	logic                         out_dropped_q;

	logic                         wr_en;
	logic [pbs_pkg::IDX_W-1:0]    wr_addr;
	logic [pbs_pkg::PAIR_W-1:0]   wr_data;
	logic                         rd_en;
	logic [pbs_pkg::IDX_W-1:0]    rd_addr;
	logic [pbs_pkg::PAIR_W-1:0]   rd_data;
	logic                         greater;
	logic                         out_free;
	logic                         emit_last;
	logic                         has_room;

	pbs_ram #(
		.WIDTH(pbs_pkg::PAIR_W),
		.DEPTH(pbs_pkg::BLOCK_ENTRIES)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign greater   = rd_data > item_q;
	assign out_free  = !out_valid_q || sorted.ready;
	assign emit_last = (pbs_pkg::CNT_W'(emit_q) + pbs_pkg::CNT_W'(1)) == fill_q;
	assign has_room  = fill_q < pbs_pkg::CNT_W'(pbs_pkg::BLOCK_ENTRIES);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = item_q;
		rd_en   = 1'b0;
		rd_addr = pos_q - pbs_pkg::IDX_W'(1);
		case (state_q)
			INS_RD: begin
				if (pos_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en = 1'b1;
				end
			end
			INS_CMP: begin
				wr_en   = 1'b1;
				wr_data = greater ? rd_data : item_q;
			end
			EMIT_RD: begin
				rd_en   = 1'b1;
				rd_addr = emit_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			fill_q        <= '0;
			ovf_q         <= 1'b0;
			pos_q         <= '0;
			emit_q        <= '0;
			item_q        <= '0;
			last_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			out_high_q    <= '0;
			out_low_q     <= '0;
			out_run_end_q <= 1'b0;
			out_dropped_q <= 1'b0;
		end else begin
			if (out_valid_q && sorted.ready && state_q != EMIT_LD) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (pairs.valid) begin
						item_q <= {pairs.key_high, pairs.key_low};
						last_q <= pairs.block_end;
						emit_q <= '0;
						if (has_room) begin
							pos_q   <= fill_q[pbs_pkg::IDX_W-1:0];
							fill_q  <= fill_q + pbs_pkg::CNT_W'(1);
							state_q <= INS_RD;
						end else begin
							ovf_q <= 1'b1;
							if (pairs.block_end) begin
								state_q <= EMIT_RD;
							end
						end
					end
				end
				INS_RD: begin
					if (pos_q == '0) begin
						state_q <= last_q ? EMIT_RD : IDLE;
					end else begin
						state_q <= INS_CMP;
					end
				end
				INS_CMP: begin
					if (greater) begin
						pos_q   <= pos_q - pbs_pkg::IDX_W'(1);
						state_q <= INS_RD;
					end else begin
						state_q <= last_q ? EMIT_RD : IDLE;
					end
				end
				EMIT_RD: begin
					state_q <= EMIT_LD;
				end
				EMIT_LD: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_high_q    <= rd_data[pbs_pkg::PAIR_W-1:pbs_pkg::KEY_W];
						out_low_q     <= rd_data[pbs_pkg::KEY_W-1:0];
						out_run_end_q <= emit_last;
						out_dropped_q <= ovf_q;
						if (emit_last) begin
							fill_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= IDLE;
						end else begin
							emit_q  <= emit_q + pbs_pkg::IDX_W'(1);
							state_q <= EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign pairs.ready     = state_q == IDLE;
	assign sorted.valid    = out_valid_q;
	assign sorted.out_high = out_high_q;
	assign sorted.out_low  = out_low_q;
	assign sorted.run_end  = out_run_end_q;
	assign sorted.dropped  = out_dropped_q;

	`PBS_ASSERT_IMP(a_write_only_inserting, clk, arst_n, wr_en, state_q == INS_RD || state_q == INS_CMP)
	`PBS_ASSERT_IMP(a_fill_bounded, clk, arst_n, 1'b1, fill_q <= pbs_pkg::CNT_W'(pbs_pkg::BLOCK_ENTRIES))
	`PBS_ASSERT_IMP(a_block_open_midrun, clk, arst_n, sorted.valid && !sorted.run_end, fill_q != '0)
	`PBS_ASSERT_NXT(a_drop_taken_once, clk, arst_n, pairs.valid && pairs.ready && !has_room, ovf_q)

endmodule
